// ===== sv/pvs_pkg.sv =====
// shared types, codes and helpers of the vip score engine
package pvs_pkg;

    localparam int MAX_FEATURES_DEF   = 1024;
    localparam int MAX_COMPONENTS_DEF = 16;

    // command codes
    localparam logic [2:0] CMD_LOAD  = 3'd0;
    localparam logic [2:0] CMD_SCORE = 3'd1;
    localparam logic [2:0] CMD_YLOAD = 3'd2;
    localparam logic [2:0] CMD_QUERY = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_VANISHED = 2'd1;
    localparam logic [1:0] STAT_RANGE    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_FEATURES   = 2'd0;
    localparam logic [1:0] REG_COMPONENTS = 2'd1;
    localparam logic [1:0] REG_THRESHOLD  = 2'd2;

    // accumulator banks
    localparam logic [1:0] BANK_SCORE = 2'd0;
    localparam logic [1:0] BANK_YLOAD = 2'd1;
    localparam logic [1:0] BANK_WSS   = 2'd2;

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    typedef struct packed {
        logic [2:0]         command;
        logic [9:0]         row_index;
        logic [3:0]         component_index;
        logic signed [23:0] value;
    } request_t;

    typedef struct packed {
        logic [23:0] vip_value;
        logic [9:0]  feature_echo;
        logic [1:0]  status;
    } result_t;

    // exact square of a signed 24-bit value
    function automatic logic [47:0] square24(input logic [23:0] v);
        logic [23:0] m;
        m = v[23] ? (24'd0 - v) : v;
        return 48'(m) * 48'(m);
    endfunction

endpackage

// ===== sv/pvs_weight_ram.sv =====
// weight store memory, one write and one registered read port
module pvs_weight_ram #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [23:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [23:0]   rd_data
);

    logic [23:0] mem [DEPTH];
    logic [23:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/pvs_accum_ram.sv =====
// accumulator memory with per-entry valid bits, unwritten entries read as zero
module pvs_accum_ram #(
    parameter int DEPTH = 48,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [63:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [63:0]   rd_data
);

    logic [63:0]      mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [63:0]      rd_data_reg;
    logic             rd_valid_reg;

    // data array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // valid bits, cleared at reset and on clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : 64'd0;

endmodule

// ===== sv/pvs_mul64.sv =====
// 64x64 multiplier over four 32x32 partial products
module pvs_mul64 (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] prod
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_sh_reg;
    logic [127:0] acc_reg;
    logic [2:0]   cnt_reg;
    logic         run_reg;
    logic         done_reg;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] pp_shifted;

    // partial product operand select
    always_comb
    begin
        a_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        case (pp_sh_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd1:    pp_shifted = {32'd0, pp_reg, 32'd0};
            default: pp_shifted = {pp_reg, 64'd0};
        endcase
    end

    // sequencing and accumulation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg     <= '0;
            b_reg     <= '0;
            pp_reg    <= '0;
            pp_sh_reg <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg   <= a;
                b_reg   <= b;
                acc_reg <= '0;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (cnt_reg != 3'd4)
                begin
                    pp_reg    <= 64'(a_half) * 64'(b_half);
                    pp_sh_reg <= 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
                end
                if (cnt_reg != 3'd0)
                begin
                    acc_reg <= acc_reg + pp_shifted;
                end
                if (cnt_reg == 3'd4)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== sv/pvs_ratio.sv =====
// Q1.32 ratio unit: bit-serial normalize then restoring divide, capped at one
module pvs_ratio (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] num,
    input  logic [127:0] den,
    output logic         done,
    output logic [32:0]  quot
);
    import pvs_pkg::*;

    typedef enum logic [1:0] {R_IDLE, R_SHIFT, R_DIV} rstate_t;

    rstate_t      state_reg;
    logic [127:0] num_reg;
    logic [127:0] den_reg;
    logic [31:0]  rem_reg;
    logic [32:0]  q_reg;
    logic [4:0]   cnt_reg;
    logic         done_reg;
    logic [32:0]  rem2;
    logic         sub_ok;

    always_comb
    begin
        rem2   = {rem_reg, 1'b0};
        sub_ok = rem2 >= {1'b0, den_reg[31:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            num_reg   <= '0;
            den_reg   <= '0;
            rem_reg   <= '0;
            q_reg     <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        num_reg   <= num;
                        den_reg   <= den;
                        state_reg <= R_SHIFT;
                    end
                end
                // shift both until the divisor fits in 32 bits
                R_SHIFT:
                begin
                    if (den_reg[127:32] != '0)
                    begin
                        num_reg <= num_reg >> 1;
                        den_reg <= den_reg >> 1;
                    end
                    else if (den_reg[31:0] == '0 || num_reg[127:64] != '0
                             || num_reg[63:0] >= {32'd0, den_reg[31:0]})
                    begin
                        q_reg     <= ONE_Q32;
                        done_reg  <= 1'b1;
                        state_reg <= R_IDLE;
                    end
                    else
                    begin
                        rem_reg   <= num_reg[31:0];
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= R_DIV;
                    end
                end
                // one quotient bit per cycle
                R_DIV:
                begin
                    rem_reg <= sub_ok ? 32'(rem2 - {1'b0, den_reg[31:0]}) : rem2[31:0];
                    q_reg   <= {q_reg[31:0], sub_ok};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= R_IDLE;
                    end
                end
                default: state_reg <= R_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== sv/pvs_isqrt.sv =====
// 64-bit floor square root, two radicand bits per cycle
module pvs_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [4:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                v_reg   <= radicand;
                res_reg <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (v_reg >= trial)
                begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

// ===== sv/pls_vip_score_engine.sv =====
// vip score engine top level: command decode, query sequencer and config registers
//
// Requests enter on request when start is high and busy is low. Load weight,
// add score, add y loading and clear requests read the accumulator memory at
// the request edge and write it back, if in range, at the next edge (a clear
// instead empties every entry), with busy high in between. Unknown commands do nothing.
// A query request gives exactly one result, shown on result for one cycle
// with result_valid high; the receiver cannot stall, so it must take it.
// An out-of-range query answers the cycle after the request. Otherwise a
// query with k components runs a variance pass over all k components, then
// per kept component two ratio divides (each a bit-serial normalize of up to
// 96 steps and 32 quotient steps) and up to two four-step multiplies, and
// at last the scale multiply and the 32-step square root.
// Configuration writes on cfg_write/cfg_index/cfg_data take effect at once
// and must only be made while the block is idle; the block does not enforce
// it. Reset clears the accumulators through their valid bits; the weight
// store is not cleared.
module pls_vip_score_engine #(
    parameter int MAX_FEATURES   = pvs_pkg::MAX_FEATURES_DEF,
    parameter int MAX_COMPONENTS = pvs_pkg::MAX_COMPONENTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pvs_pkg::request_t request,
    output logic              result_valid,
    output pvs_pkg::result_t  result,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import pvs_pkg::*;

    localparam int CW  = $clog2(MAX_COMPONENTS + 1);
    localparam int AD  = 3 * MAX_COMPONENTS;
    localparam int AAW = $clog2(AD);
    localparam int WD  = MAX_FEATURES * MAX_COMPONENTS;
    localparam int WAW = (WD > 1) ? $clog2(WD) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_LD_WR,
        S_P1_RD_T, S_P1_RD_Q, S_P1_MUL, S_P1_MUL_W,
        S_VCHK,
        S_P2_RD_W, S_P2_RD_T, S_P2_RD_Q, S_P2_MUL, S_P2_MUL_W,
        S_P2_DIV_F, S_P2_DIV_R, S_P2_MUL_FR,
        S_FIN, S_FIN_MUL, S_FIN_SQRT
    } state_t;

    state_t         state_reg;
    logic [10:0]    feat_reg;
    logic [4:0]     comp_cfg_reg;
    logic [15:0]    thr_reg;
    logic [9:0]     row_reg;
    logic [CW-1:0]  c_reg;
    logic [CW-1:0]  k_reg;
    logic [AAW-1:0] acc_waddr_reg;
    logic           wr_ok_reg;
    logic           clr_reg;
    logic [47:0]    sq_reg;
    logic [63:0]    tss_reg;
    logic [63:0]    wss_reg;
    logic [127:0]   total_reg;
    logic [32:0]    f_reg;
    logic [63:0]    acc_reg;
    logic           done_reg;
    result_t        result_reg;

    logic           accept;
    logic           row_ok;
    logic           comp_ok;
    logic [1:0]     in_bank;
    logic [1:0]     rd_bank;
    logic [AAW-1:0] acc_raddr;
    logic [63:0]    acc_rdata;
    logic [64:0]    acc_sum;
    logic           acc_wr_en;
    logic [63:0]    acc_wdata;
    logic           w_wr_en;
    logic [WAW-1:0] w_waddr;
    logic [WAW-1:0] w_raddr;
    logic [23:0]    w_rdata;
    logic [128:0]   total_sum;
    logic [CW-1:0]  k_calc;

    logic           mul_start;
    logic [63:0]    mul_a;
    logic [63:0]    mul_b;
    logic           mul_done;
    logic [127:0]   mul_prod;
    logic           rat_start;
    logic [127:0]   rat_num;
    logic [127:0]   rat_den;
    logic           rat_done;
    logic [32:0]    rat_q;
    logic           sqrt_start;
    logic           sqrt_done;
    logic [31:0]    sqrt_root;

    // request decode
    always_comb
    begin
        accept  = start && (state_reg == S_IDLE);
        row_ok  = 32'(request.row_index) < MAX_FEATURES;
        comp_ok = 32'(request.component_index) < MAX_COMPONENTS;
        case (request.command)
            CMD_SCORE: in_bank = BANK_SCORE;
            CMD_YLOAD: in_bank = BANK_YLOAD;
            default:   in_bank = BANK_WSS;
        endcase
        k_calc = (32'(comp_cfg_reg) > MAX_COMPONENTS) ? CW'(MAX_COMPONENTS)
                                                       : CW'(comp_cfg_reg);
    end

    // accumulator read address
    always_comb
    begin
        case (state_reg) inside
            S_P1_RD_Q, S_P2_RD_Q: rd_bank = BANK_YLOAD;
            S_P2_RD_W:            rd_bank = BANK_WSS;
            default:              rd_bank = BANK_SCORE;
        endcase
        if (state_reg == S_IDLE)
        begin
            acc_raddr = AAW'(32'(in_bank) * MAX_COMPONENTS + 32'(request.component_index));
        end
        else
        begin
            acc_raddr = AAW'(32'(rd_bank) * MAX_COMPONENTS + 32'(c_reg));
        end
    end

    // saturating accumulator update and weight store ports
    always_comb
    begin
        acc_sum   = {1'b0, acc_rdata} + {17'd0, sq_reg};
        acc_wdata = acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0];
        acc_wr_en = (state_reg == S_LD_WR) && wr_ok_reg && !clr_reg;
        w_wr_en   = accept && (request.command == CMD_LOAD) && row_ok && comp_ok;
        w_waddr   = WAW'(32'(request.row_index) * MAX_COMPONENTS
                         + 32'(request.component_index));
        w_raddr   = WAW'(32'(row_reg) * MAX_COMPONENTS + 32'(c_reg));
        total_sum = {1'b0, total_reg} + {1'b0, mul_prod};
    end

    // shared unit starts and operands
    always_comb
    begin
        mul_start  = 1'b0;
        mul_a      = tss_reg;
        mul_b      = acc_rdata;
        rat_start  = 1'b0;
        rat_num    = mul_prod;
        rat_den    = total_reg;
        sqrt_start = 1'b0;
        case (state_reg) inside
            S_P1_MUL, S_P2_MUL: mul_start = 1'b1;
            S_P2_MUL_W:         rat_start = mul_done;
            S_P2_DIV_F:
            begin
                rat_start = rat_done;
                rat_num   = {80'd0, sq_reg};
                rat_den   = {64'd0, wss_reg};
            end
            S_P2_DIV_R:
            begin
                mul_start = rat_done && (f_reg != ONE_Q32);
                mul_a     = {31'd0, f_reg};
                mul_b     = {31'd0, rat_q};
            end
            S_FIN:
            begin
                mul_start = 1'b1;
                mul_a     = acc_reg;
                mul_b     = {53'd0, feat_reg};
            end
            S_FIN_MUL: sqrt_start = mul_done;
            default:   mul_start = 1'b0;
        endcase
    end

    // sequencer, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            feat_reg      <= 11'd1024;
            comp_cfg_reg  <= 5'd16;
            thr_reg       <= 16'd1;
            row_reg       <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            acc_waddr_reg <= '0;
            wr_ok_reg     <= 1'b0;
            clr_reg       <= 1'b0;
            sq_reg        <= '0;
            tss_reg       <= '0;
            wss_reg       <= '0;
            total_reg     <= '0;
            f_reg         <= '0;
            acc_reg       <= '0;
            done_reg      <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_FEATURES:   feat_reg     <= cfg_data[10:0];
                    REG_COMPONENTS: comp_cfg_reg <= cfg_data[4:0];
                    REG_THRESHOLD:  thr_reg      <= cfg_data;
                    default:        thr_reg      <= thr_reg;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        sq_reg        <= square24(request.value);
                        acc_waddr_reg <= acc_raddr;
                        row_reg       <= request.row_index;
                        clr_reg       <= request.command == CMD_CLEAR;
                        case (request.command) inside
                            CMD_LOAD:
                            begin
                                wr_ok_reg <= row_ok && comp_ok;
                                state_reg <= S_LD_WR;
                            end
                            CMD_SCORE, CMD_YLOAD, CMD_CLEAR:
                            begin
                                wr_ok_reg <= comp_ok;
                                state_reg <= S_LD_WR;
                            end
                            CMD_QUERY:
                            begin
                                result_reg.feature_echo <= request.row_index;
                                if (({1'b0, request.row_index} >= feat_reg) || !row_ok)
                                begin
                                    result_reg.vip_value <= '0;
                                    result_reg.status    <= STAT_RANGE;
                                    done_reg             <= 1'b1;
                                end
                                else
                                begin
                                    k_reg     <= k_calc;
                                    c_reg     <= '0;
                                    total_reg <= '0;
                                    state_reg <= S_P1_RD_T;
                                end
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_LD_WR: state_reg <= S_IDLE;
                // total explained variance pass
                S_P1_RD_T: state_reg <= (c_reg == k_reg) ? S_VCHK : S_P1_RD_Q;
                S_P1_RD_Q:
                begin
                    tss_reg   <= acc_rdata;
                    state_reg <= S_P1_MUL;
                end
                S_P1_MUL: state_reg <= S_P1_MUL_W;
                S_P1_MUL_W:
                begin
                    if (mul_done)
                    begin
                        total_reg <= total_sum[128] ? {128{1'b1}} : total_sum[127:0];
                        c_reg     <= c_reg + CW'(1);
                        state_reg <= S_P1_RD_T;
                    end
                end
                S_VCHK:
                begin
                    if (total_reg[127:64] == '0 && total_reg[63:0] <= 64'(thr_reg))
                    begin
                        result_reg.vip_value <= '0;
                        result_reg.status    <= STAT_VANISHED;
                        done_reg             <= 1'b1;
                        state_reg            <= S_IDLE;
                    end
                    else
                    begin
                        c_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_P2_RD_W;
                    end
                end
                // per component contribution pass
                S_P2_RD_W: state_reg <= (c_reg == k_reg) ? S_FIN : S_P2_RD_T;
                S_P2_RD_T:
                begin
                    sq_reg  <= square24(w_rdata);
                    wss_reg <= acc_rdata;
                    if (acc_rdata <= 64'(thr_reg))
                    begin
                        c_reg     <= c_reg + CW'(1);
                        state_reg <= S_P2_RD_W;
                    end
                    else
                    begin
                        state_reg <= S_P2_RD_Q;
                    end
                end
                S_P2_RD_Q:
                begin
                    tss_reg   <= acc_rdata;
                    state_reg <= S_P2_MUL;
                end
                S_P2_MUL: state_reg <= S_P2_MUL_W;
                S_P2_MUL_W:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_P2_DIV_F;
                    end
                end
                S_P2_DIV_F:
                begin
                    if (rat_done)
                    begin
                        f_reg     <= rat_q;
                        state_reg <= S_P2_DIV_R;
                    end
                end
                S_P2_DIV_R:
                begin
                    if (rat_done)
                    begin
                        if (f_reg == ONE_Q32)
                        begin
                            acc_reg   <= acc_reg + 64'(rat_q);
                            c_reg     <= c_reg + CW'(1);
                            state_reg <= S_P2_RD_W;
                        end
                        else
                        begin
                            state_reg <= S_P2_MUL_FR;
                        end
                    end
                end
                S_P2_MUL_FR:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= acc_reg + mul_prod[95:32];
                        c_reg     <= c_reg + CW'(1);
                        state_reg <= S_P2_RD_W;
                    end
                end
                // scale by p and take the root
                S_FIN: state_reg <= S_FIN_MUL;
                S_FIN_MUL:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_FIN_SQRT;
                    end
                end
                S_FIN_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        result_reg.vip_value <= (sqrt_root[31:24] != '0) ? 24'hFF_FFFF
                                                                         : sqrt_root[23:0];
                        result_reg.status    <= STAT_OK;
                        done_reg             <= 1'b1;
                        state_reg            <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    pvs_weight_ram #(
        .DEPTH (WD),
        .AW    (WAW)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (w_wr_en),
        .wr_addr (w_waddr),
        .wr_data (request.value),
        .rd_addr (w_raddr),
        .rd_data (w_rdata)
    );

    pvs_accum_ram #(
        .DEPTH (AD),
        .AW    (AAW)
    ) u_accum_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   ((state_reg == S_LD_WR) && clr_reg),
        .wr_en   (acc_wr_en),
        .wr_addr (acc_waddr_reg),
        .wr_data (acc_wdata),
        .rd_addr (acc_raddr),
        .rd_data (acc_rdata)
    );

    pvs_mul64 u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pvs_ratio u_ratio (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rat_start),
        .num   (rat_num),
        .den   (rat_den),
        .done  (rat_done),
        .quot  (rat_q)
    );

    pvs_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (mul_prod[63:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign busy         = state_reg != S_IDLE;
    assign result_valid = done_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // root unit only finishes while the sequencer waits for it
    a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> state_reg == S_FIN_SQRT)
        else $error("root done outside final state");

    // ratio unit only finishes in a divide wait state
    a_rat_done: assert property (@(posedge clk) disable iff (!rst_n)
        rat_done |-> (state_reg == S_P2_DIV_F || state_reg == S_P2_DIV_R))
        else $error("ratio done outside divide wait");

    // an ok result always follows the root step
    a_ok_src: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == STAT_OK) |-> $past(state_reg) == S_FIN_SQRT)
        else $error("ok result without root step");
`endif

endmodule
